>>> rtl/core/sequence_dedup_nack_tracker_assert.svh
// Assertion macros for the sequence dedup / NACK tracker checker.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef SEQUENCE_DEDUP_NACK_TRACKER_ASSERT_SVH
`define SEQUENCE_DEDUP_NACK_TRACKER_ASSERT_SVH

// same-cycle implication, clocked on clk, off during reset
`define SDNT_ASSERT_SAME(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sdnt: same-cycle check failed");

// next-cycle implication
`define SDNT_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sdnt: next-cycle check failed");

`endif

>>> rtl/core/sdnt_pkg.sv
// Shared types and constants for the sequence dedup / NACK tracker.
// No dependencies.
package sdnt_pkg;

    localparam int SEQ_W   = 15;
    localparam int LEN_W   = 12;
    localparam int HDR_W   = 16;
    localparam int CFG_W   = 16;
    localparam int LIMIT_W = 6;
    localparam int TICK_W  = 16;
    localparam int RED_FLAG_BIT = 15;

    localparam logic [LEN_W-1:0]   MIN_LEN      = 12'd162;
    localparam logic [LEN_W-1:0]   MIN_RED_LEN  = 12'd324;
    localparam logic [LIMIT_W-1:0] LIMIT_CAP    = 6'd62;
    localparam logic [TICK_W-1:0]  TICK_MAX     = 16'hFFFF;
    localparam logic [SEQ_W-1:0]   RST_LOOK_BACK = 15'd100;
    localparam logic [SEQ_W-1:0]   RST_GUARD_GAP = 15'd4;
    localparam logic [LIMIT_W-1:0] RST_LIMIT     = 6'd62;
    localparam logic [TICK_W-1:0]  RST_INTERVAL  = 16'd20;

    typedef enum logic [1:0] {
        CFG_LOOK_BACK     = 2'd0,
        CFG_GUARD_GAP     = 2'd1,
        CFG_REPORT_LIMIT  = 2'd2,
        CFG_SCAN_INTERVAL = 2'd3
    } cfg_idx_t;

    typedef enum logic {
        KIND_FORWARD = 1'b0,
        KIND_MISSING = 1'b1
    } kind_t;

    // which sequence a read, mark or result refers to
    typedef enum logic [1:0] {
        SRC_PRIMARY   = 2'd0,
        SRC_REDUNDANT = 2'd1,
        SRC_SCAN      = 2'd2
    } seq_src_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_P_RD,
        ST_P_CHK,
        ST_R_RD,
        ST_R_CHK,
        ST_SC_DEC,
        ST_SC_INIT,
        ST_SCAN,
        ST_FLUSH
    } state_t;

    typedef struct packed {
        logic     clr_step;
        logic     latch;
        logic     tick;
        logic     upd_high;
        logic     rd_en;
        seq_src_t src;
        logic     mark;
        logic     push;
        logic     scan_take;
        logic     scan_init;
        logic     scan_step;
        logic     scan_issue;
        logic     flush;
    } cmd_t;

    typedef struct packed {
        logic clr_done;
        logic is_tick;
        logic len_ok;
        logic red_ok;
        logic seen;
        logic res_ok;
        logic scan_due;
        logic scan_nonempty;
        logic scan_hit;
        logic scan_more;
    } status_t;

endpackage

>>> rtl/core/sdnt_if.sv
// Valid/ready channel interfaces for the tracker's input and result streams.
// Depends on sdnt_pkg for field widths.
interface sdnt_in_if;
    logic                        valid;
    logic                        ready;
    logic                        action;
    logic [sdnt_pkg::LEN_W-1:0]  packet_length;
    logic [sdnt_pkg::HDR_W-1:0]  header_word;
    logic [sdnt_pkg::HDR_W-1:0]  redundant_word;

    modport source (output valid, action, packet_length, header_word, redundant_word,
                    input ready);
    modport sink   (input valid, action, packet_length, header_word, redundant_word,
                    output ready);
endinterface

interface sdnt_out_if;
    logic                        valid;
    logic                        ready;
    logic                        kind;
    logic [sdnt_pkg::SEQ_W-1:0]  sequence_res;
    logic                        last;

    modport source (output valid, kind, sequence_res, last, input ready);
    modport sink   (input valid, kind, sequence_res, last, output ready);
endinterface

>>> rtl/core/sdnt_datapath.sv
// Datapath: config registers, seen bitmap memory, sequence/tick state,
// scan counters and the pending/output result registers. Uses sdnt_pkg.
module sdnt_datapath #(
    parameter int SEQ_SPACE = 32768
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  sdnt_pkg::cmd_t                cmd,
    output sdnt_pkg::status_t             sts,
    input  logic                          cfg_we,
    input  logic [1:0]                    cfg_index,
    input  logic [sdnt_pkg::CFG_W-1:0]    cfg_data,
    input  logic                          in_action,
    input  logic [sdnt_pkg::LEN_W-1:0]    in_length,
    input  logic [sdnt_pkg::HDR_W-1:0]    in_header,
    input  logic [sdnt_pkg::HDR_W-1:0]    in_redundant,
    input  logic                          out_ready,
    output logic                          out_valid,
    output logic                          out_kind,
    output logic [sdnt_pkg::SEQ_W-1:0]    out_seq,
    output logic                          out_last
);
    localparam int AW = $clog2(SEQ_SPACE);

    // configuration
    logic [sdnt_pkg::SEQ_W-1:0]   look_back_reg;
    logic [sdnt_pkg::SEQ_W-1:0]   guard_gap_reg;
    logic [sdnt_pkg::LIMIT_W-1:0] report_limit_reg;
    logic [sdnt_pkg::TICK_W-1:0]  scan_interval_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            look_back_reg     <= sdnt_pkg::RST_LOOK_BACK;
            guard_gap_reg     <= sdnt_pkg::RST_GUARD_GAP;
            report_limit_reg  <= sdnt_pkg::RST_LIMIT;
            scan_interval_reg <= sdnt_pkg::RST_INTERVAL;
        end
        else if (cfg_we)
        begin
            case (sdnt_pkg::cfg_idx_t'(cfg_index))
                sdnt_pkg::CFG_LOOK_BACK:     look_back_reg     <= cfg_data[sdnt_pkg::SEQ_W-1:0];
                sdnt_pkg::CFG_GUARD_GAP:     guard_gap_reg     <= cfg_data[sdnt_pkg::SEQ_W-1:0];
                sdnt_pkg::CFG_REPORT_LIMIT:  report_limit_reg  <= cfg_data[sdnt_pkg::LIMIT_W-1:0];
                sdnt_pkg::CFG_SCAN_INTERVAL: scan_interval_reg <= cfg_data;
                default:                     look_back_reg     <= look_back_reg;
            endcase
        end
    end

    // latched packet fields
    logic [sdnt_pkg::SEQ_W-1:0] seq_reg;
    logic [sdnt_pkg::SEQ_W-1:0] red_reg;
    logic                       red_use_reg;
    logic [sdnt_pkg::SEQ_W-1:0] in_seq;

    assign in_seq = in_header[sdnt_pkg::SEQ_W-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            seq_reg     <= in_seq;
            red_reg     <= in_redundant[sdnt_pkg::SEQ_W-1:0];
            red_use_reg <= in_header[sdnt_pkg::RED_FLAG_BIT] &&
                           (in_length >= sdnt_pkg::MIN_RED_LEN);
        end
    end

    // highest sequence and tick count
    logic [sdnt_pkg::SEQ_W-1:0]  highest_reg;
    logic                        hvalid_reg;
    logic [sdnt_pkg::TICK_W-1:0] elapsed_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            highest_reg <= '0;
            hvalid_reg  <= 1'b0;
            elapsed_reg <= sdnt_pkg::TICK_MAX;
        end
        else
        begin
            if (cmd.upd_high && (!hvalid_reg || in_seq > highest_reg))
            begin
                highest_reg <= in_seq;
                hvalid_reg  <= 1'b1;
            end
            if (cmd.scan_take)
                elapsed_reg <= '0;
            else if (cmd.tick && elapsed_reg != sdnt_pkg::TICK_MAX)
                elapsed_reg <= elapsed_reg + 16'd1;
        end
    end

    // scan window
    logic [sdnt_pkg::SEQ_W:0]     scan_i_reg;
    logic [sdnt_pkg::SEQ_W-1:0]   end_reg;
    logic [sdnt_pkg::LIMIT_W-1:0] limit_reg;
    logic [sdnt_pkg::LIMIT_W-1:0] found_reg;
    logic                         chk_valid_reg;
    logic [sdnt_pkg::SEQ_W-1:0]   chk_seq_reg;
    logic [sdnt_pkg::LIMIT_W-1:0] limit_w;
    logic [sdnt_pkg::SEQ_W-1:0]   start_w;
    logic [sdnt_pkg::LIMIT_W:0]   found_sum;
    logic                         rdata_reg;

    assign limit_w = (report_limit_reg > sdnt_pkg::LIMIT_CAP) ? sdnt_pkg::LIMIT_CAP
                                                               : report_limit_reg;
    assign start_w = (highest_reg >= look_back_reg) ? (highest_reg - look_back_reg) : '0;
    assign found_sum = {1'b0, found_reg} + {{sdnt_pkg::LIMIT_W{1'b0}}, sts.scan_hit};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chk_valid_reg <= 1'b0;
            found_reg     <= '0;
        end
        else if (cmd.scan_init)
        begin
            chk_valid_reg <= 1'b0;
            found_reg     <= '0;
        end
        else if (cmd.scan_step)
        begin
            chk_valid_reg <= cmd.scan_issue;
            if (cmd.push)
                found_reg <= found_sum[sdnt_pkg::LIMIT_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.scan_init)
        begin
            scan_i_reg <= {1'b0, start_w};
            end_reg    <= highest_reg - guard_gap_reg;
            limit_reg  <= limit_w;
        end
        else if (cmd.scan_issue)
        begin
            scan_i_reg  <= scan_i_reg + 16'd1;
            chk_seq_reg <= scan_i_reg[sdnt_pkg::SEQ_W-1:0];
        end
    end

    // seen bitmap, cleared by a sweep after reset
    logic [AW-1:0] clr_addr_reg;
    logic [AW-1:0] src_addr;
    logic [AW-1:0] waddr;
    logic          we;
    logic          wdata;
    logic          mem [SEQ_SPACE];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clr_addr_reg <= '0;
        else if (cmd.clr_step)
            clr_addr_reg <= clr_addr_reg + AW'(1);
    end

    always_comb
    begin
        case (cmd.src)
            sdnt_pkg::SRC_PRIMARY:   src_addr = seq_reg[AW-1:0];
            sdnt_pkg::SRC_REDUNDANT: src_addr = red_reg[AW-1:0];
            sdnt_pkg::SRC_SCAN:      src_addr = scan_i_reg[AW-1:0];
            default:                 src_addr = seq_reg[AW-1:0];
        endcase
    end

    assign we    = cmd.clr_step || cmd.mark;
    assign waddr = cmd.clr_step ? clr_addr_reg : src_addr;
    assign wdata = !cmd.clr_step;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (cmd.rd_en)
            rdata_reg <= mem[src_addr];
    end

    // results: one held back so the final one can carry last
    logic                       pend_valid_reg;
    logic                       pend_kind_reg;
    logic [sdnt_pkg::SEQ_W-1:0] pend_seq_reg;
    logic                       out_valid_reg;
    logic                       out_kind_reg;
    logic [sdnt_pkg::SEQ_W-1:0] out_seq_reg;
    logic                       out_last_reg;
    logic                       new_kind;
    logic [sdnt_pkg::SEQ_W-1:0] new_seq;
    logic                       out_load;

    always_comb
    begin
        case (cmd.src)
            sdnt_pkg::SRC_PRIMARY:
            begin
                new_kind = sdnt_pkg::KIND_FORWARD;
                new_seq  = seq_reg;
            end
            sdnt_pkg::SRC_REDUNDANT:
            begin
                new_kind = sdnt_pkg::KIND_FORWARD;
                new_seq  = red_reg;
            end
            sdnt_pkg::SRC_SCAN:
            begin
                new_kind = sdnt_pkg::KIND_MISSING;
                new_seq  = chk_seq_reg;
            end
            default:
            begin
                new_kind = sdnt_pkg::KIND_FORWARD;
                new_seq  = seq_reg;
            end
        endcase
    end

    assign out_load = (cmd.push || cmd.flush) && pend_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.push)
                pend_valid_reg <= 1'b1;
            else if (cmd.flush)
                pend_valid_reg <= 1'b0;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            pend_kind_reg <= new_kind;
            pend_seq_reg  <= new_seq;
        end
        if (out_load)
        begin
            out_kind_reg <= pend_kind_reg;
            out_seq_reg  <= pend_seq_reg;
            out_last_reg <= cmd.flush;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_kind  = out_kind_reg;
    assign out_seq   = out_seq_reg;
    assign out_last  = out_last_reg;

    // status
    assign sts.clr_done      = (clr_addr_reg == AW'(SEQ_SPACE - 1));
    assign sts.is_tick       = in_action;
    assign sts.len_ok        = (in_length >= sdnt_pkg::MIN_LEN);
    assign sts.red_ok        = red_use_reg;
    assign sts.seen          = rdata_reg;
    assign sts.res_ok        = !pend_valid_reg || !out_valid_reg || out_ready;
    assign sts.scan_due      = hvalid_reg && (elapsed_reg >= scan_interval_reg);
    assign sts.scan_nonempty = (highest_reg >= guard_gap_reg) && (limit_w != '0);
    assign sts.scan_hit      = chk_valid_reg && !rdata_reg && (found_reg < limit_reg);
    assign sts.scan_more     = (scan_i_reg <= {1'b0, end_reg}) &&
                               (found_sum < {1'b0, limit_reg});

endmodule

>>> rtl/core/sdnt_controller.sv
// Controller state machine: sequences bitmap clear, dedup checks, the
// missing scan and the final flush. Uses sdnt_pkg.
module sdnt_controller (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  sdnt_pkg::status_t sts,
    output sdnt_pkg::cmd_t    cmd
);
    sdnt_pkg::state_t state_reg;
    sdnt_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= sdnt_pkg::ST_CLEAR;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        cmd.src    = sdnt_pkg::SRC_PRIMARY;
        case (state_reg)
            sdnt_pkg::ST_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (sts.clr_done)
                    state_next = sdnt_pkg::ST_IDLE;
            end
            sdnt_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.latch = 1'b1;
                    if (sts.is_tick)
                        cmd.tick = 1'b1;
                    else if (sts.len_ok)
                    begin
                        cmd.upd_high = 1'b1;
                        state_next   = sdnt_pkg::ST_P_RD;
                    end
                end
            end
            sdnt_pkg::ST_P_RD:
            begin
                cmd.rd_en  = 1'b1;
                state_next = sdnt_pkg::ST_P_CHK;
            end
            sdnt_pkg::ST_P_CHK:
            begin
                if (sts.seen || sts.res_ok)
                begin
                    cmd.mark   = !sts.seen;
                    cmd.push   = !sts.seen;
                    state_next = sts.red_ok ? sdnt_pkg::ST_R_RD : sdnt_pkg::ST_SC_DEC;
                end
            end
            sdnt_pkg::ST_R_RD:
            begin
                cmd.src    = sdnt_pkg::SRC_REDUNDANT;
                cmd.rd_en  = 1'b1;
                state_next = sdnt_pkg::ST_R_CHK;
            end
            sdnt_pkg::ST_R_CHK:
            begin
                cmd.src = sdnt_pkg::SRC_REDUNDANT;
                if (sts.seen || sts.res_ok)
                begin
                    cmd.mark   = !sts.seen;
                    cmd.push   = !sts.seen;
                    state_next = sdnt_pkg::ST_SC_DEC;
                end
            end
            sdnt_pkg::ST_SC_DEC:
            begin
                if (sts.scan_due)
                begin
                    cmd.scan_take = 1'b1;
                    state_next = sts.scan_nonempty ? sdnt_pkg::ST_SC_INIT : sdnt_pkg::ST_FLUSH;
                end
                else
                    state_next = sdnt_pkg::ST_FLUSH;
            end
            sdnt_pkg::ST_SC_INIT:
            begin
                cmd.scan_init = 1'b1;
                state_next    = sdnt_pkg::ST_SCAN;
            end
            sdnt_pkg::ST_SCAN:
            begin
                // read of entry i overlaps the check of entry i-1
                cmd.src = sdnt_pkg::SRC_SCAN;
                if (!sts.scan_hit || sts.res_ok)
                begin
                    cmd.scan_step  = 1'b1;
                    cmd.push       = sts.scan_hit;
                    cmd.scan_issue = sts.scan_more;
                    cmd.rd_en      = sts.scan_more;
                    state_next = sts.scan_more ? sdnt_pkg::ST_SCAN : sdnt_pkg::ST_FLUSH;
                end
            end
            sdnt_pkg::ST_FLUSH:
            begin
                if (sts.res_ok)
                begin
                    cmd.flush  = 1'b1;
                    state_next = sdnt_pkg::ST_IDLE;
                end
            end
            default:
                state_next = sdnt_pkg::ST_IDLE;
        endcase
    end

endmodule

>>> rtl/core/sequence_dedup_nack_tracker.sv
// Sequence duplicate filter with missing-sequence reporting.
// Input channel in_ch carries packet arrivals (action 0) and 1 ms ticks
// (action 1); result channel out_ch carries forward (kind 0) and missing
// (kind 1) transactions, last set on the final result of each input.
// Configuration is a plain write port (cfg_we, cfg_index, cfg_data).
// A tick or short packet is handled in idle. A packet has its sequence
// read and checked, then a redundant copy if used, then a scan decision,
// a scan if due and a flush. The scan reads one bitmap entry per cycle,
// unless results back up, via the single read port of the seen memory
// (at most 97 entries by default). The next input transaction is taken once
// the last result of the current one sits in the output register.
// After reset the seen bitmap is cleared one entry a cycle, all SEQ_SPACE
// entries (32768 by default); in_ch.ready stays low meanwhile, while
// configuration writes are taken throughout.
// If the receiver stalls, the output register and one held-back result
// fill and the controller waits; nothing is dropped.
// SEQ_SPACE must be a power of two.
module sequence_dedup_nack_tracker #(
    parameter int SEQ_SPACE = 32768
) (
    input  logic                       clk,
    input  logic                       rst_n,
    sdnt_in_if.sink                    in_ch,
    sdnt_out_if.source                 out_ch,
    input  logic                       cfg_we,
    input  logic [1:0]                 cfg_index,
    input  logic [sdnt_pkg::CFG_W-1:0] cfg_data
);
    sdnt_pkg::cmd_t    cmd;
    sdnt_pkg::status_t sts;
    logic              in_ready;
    logic              out_valid;
    logic              out_kind;
    logic [sdnt_pkg::SEQ_W-1:0] out_seq;
    logic              out_last;

    sdnt_controller u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    sdnt_datapath #(
        .SEQ_SPACE (SEQ_SPACE)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_action    (in_ch.action),
        .in_length    (in_ch.packet_length),
        .in_header    (in_ch.header_word),
        .in_redundant (in_ch.redundant_word),
        .out_ready    (out_ch.ready),
        .out_valid    (out_valid),
        .out_kind     (out_kind),
        .out_seq      (out_seq),
        .out_last     (out_last)
    );

    assign in_ch.ready         = in_ready;
    assign out_ch.valid        = out_valid;
    assign out_ch.kind         = out_kind;
    assign out_ch.sequence_res = out_seq;
    assign out_ch.last         = out_last;

endmodule

>>> rtl/core/sdnt_checker.sv
// Port-level checks for the sequence dedup / NACK tracker, bound to the top.
// Uses sdnt_pkg and sequence_dedup_nack_tracker_assert.svh.
`include "sequence_dedup_nack_tracker_assert.svh"

module sdnt_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_valid,
    input logic                       in_ready,
    input logic                       in_action,
    input logic [sdnt_pkg::LEN_W-1:0] in_len,
    input logic                       out_valid,
    input logic                       out_ready,
    input logic                       out_kind,
    input logic [sdnt_pkg::SEQ_W-1:0] out_seq,
    input logic                       out_last
);
    logic in_fire;

    assign in_fire = in_valid && in_ready;

    // stalled result transaction holds
    `SDNT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
        out_valid && $stable(out_kind) && $stable(out_seq) && $stable(out_last))

    // a tick never starts a new result
    `SDNT_ASSERT_NEXT(a_tick_quiet, in_fire && in_action, !$rose(out_valid))

    // a full-length packet occupies the block
    `SDNT_ASSERT_NEXT(a_pkt_busy, in_fire && !in_action && (in_len >= sdnt_pkg::MIN_LEN),
        !in_ready)

    // a short packet or tick leaves the block ready for the next transaction
    `SDNT_ASSERT_NEXT(a_short_ready, in_fire && (in_action || (in_len < sdnt_pkg::MIN_LEN)),
        in_ready)

endmodule

bind sequence_dedup_nack_tracker sdnt_checker u_sdnt_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_action (in_ch.action),
    .in_len    (in_ch.packet_length),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_kind  (out_ch.kind),
    .out_seq   (out_ch.sequence_res),
    .out_last  (out_ch.last)
);

>>> tb/testbench.sv
// Self-checking testbench for sequence_dedup_nack_tracker: duplicate filtering, redundant copies,
// missing-sequence scans, register settings and output back-pressure.
// Depends on sdnt_pkg, the sdnt_in_if / sdnt_out_if interfaces and the tracker RTL.
module testbench;

    typedef struct packed {
        sdnt_pkg::kind_t            kind;
        logic [sdnt_pkg::SEQ_W-1:0] seq;
        logic                       last;
    } nack_result_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [1:0] cfg_index;
    logic [sdnt_pkg::CFG_W-1:0] cfg_data;

    sdnt_in_if  pkt_ch ();
    sdnt_out_if res_ch ();

    sequence_dedup_nack_tracker dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (pkt_ch),
        .out_ch    (res_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // tracker state as predicted
    bit                           seen_seq [0:32767];
    logic [sdnt_pkg::SEQ_W-1:0]   top_seq;
    logic                         top_valid;
    logic [sdnt_pkg::TICK_W-1:0]  ticks_since_scan;
    logic [sdnt_pkg::SEQ_W-1:0]   win_back;
    logic [sdnt_pkg::SEQ_W-1:0]   win_guard;
    logic [sdnt_pkg::LIMIT_W-1:0] nack_limit;
    logic [sdnt_pkg::TICK_W-1:0]  scan_every;
    int unsigned                  last_scan_reads;

    nack_result_t pending_results [$];
    int errors;
    bit quiet;
    int hold_cycles;
    int stall_left;
    logic [sdnt_pkg::SEQ_W-1:0] stream_head;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    function automatic void predict_item(input logic act,
                                         input logic [sdnt_pkg::LEN_W-1:0] len,
                                         input logic [sdnt_pkg::HDR_W-1:0] hdr,
                                         input logic [sdnt_pkg::HDR_W-1:0] red);
        logic [sdnt_pkg::SEQ_W-1:0] pseq;
        logic [sdnt_pkg::SEQ_W-1:0] rseq;
        int unsigned lim;
        int unsigned found;
        int unsigned first;
        int unsigned stop;
        int unsigned i;
        nack_result_t batch [$];
        nack_result_t r;
        pseq = hdr[sdnt_pkg::SEQ_W-1:0];
        rseq = red[sdnt_pkg::SEQ_W-1:0];
        last_scan_reads = 0;
        if (act)
        begin
            if (ticks_since_scan != sdnt_pkg::TICK_MAX)
                ticks_since_scan = ticks_since_scan + 16'd1;
            return;
        end
        if (len < sdnt_pkg::MIN_LEN)
            return;
        if (!top_valid || pseq > top_seq)
        begin
            top_seq = pseq;
            top_valid = 1'b1;
        end
        if (!seen_seq[pseq])
        begin
            seen_seq[pseq] = 1'b1;
            r.kind = sdnt_pkg::KIND_FORWARD;
            r.seq = pseq;
            r.last = 1'b0;
            batch = {batch, r};
        end
        if (hdr[sdnt_pkg::RED_FLAG_BIT] && len >= sdnt_pkg::MIN_RED_LEN && !seen_seq[rseq])
        begin
            seen_seq[rseq] = 1'b1;
            r.kind = sdnt_pkg::KIND_FORWARD;
            r.seq = rseq;
            r.last = 1'b0;
            batch = {batch, r};
        end
        if (ticks_since_scan >= scan_every)
        begin
            lim = (nack_limit > sdnt_pkg::LIMIT_CAP) ? 32'(sdnt_pkg::LIMIT_CAP)
                                                    : 32'(nack_limit);
            found = 0;
            if (top_seq >= win_guard && lim > 0)
            begin
                first = (top_seq >= win_back) ? 32'(top_seq - win_back) : 0;
                stop = 32'(top_seq - win_guard);
                for (i = first; i <= stop && found < lim; i++)
                begin
                    last_scan_reads++;
                    if (!seen_seq[i])
                    begin
                        r.kind = sdnt_pkg::KIND_MISSING;
                        r.seq = sdnt_pkg::SEQ_W'(i);
                        r.last = 1'b0;
                        batch = {batch, r};
                        found++;
                    end
                end
            end
            ticks_since_scan = '0;
        end
        if (batch.size() > 0)
            batch[batch.size()-1].last = 1'b1;
        foreach (batch[k])
            pending_results = {pending_results, batch[k]};
    endfunction

    // result side: random stalls plus the long hold-off
    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            hold_cycles--;
            res_ch.ready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            res_ch.ready <= 1'b0;
        end
        else if (!quiet && $urandom_range(0, 5) == 0)
        begin
            stall_left = $urandom_range(1, 10) - 1;
            res_ch.ready <= 1'b0;
        end
        else
            res_ch.ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        nack_result_t want;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (pending_results.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected transaction: expected none, got %0d/%0d/%0d",
                         $time, res_ch.kind, res_ch.sequence_res, res_ch.last);
            end
            else
            begin
                want = pending_results.pop_front();
                if (res_ch.kind !== want.kind)
                begin
                    errors++;
                    $display("%0t: kind mismatch: expected %0d, got %0d",
                             $time, want.kind, res_ch.kind);
                end
                if (res_ch.sequence_res !== want.seq)
                begin
                    errors++;
                    $display("%0t: sequence mismatch: expected %0d, got %0d",
                             $time, want.seq, res_ch.sequence_res);
                end
                if (res_ch.last !== want.last)
                begin
                    errors++;
                    $display("%0t: last mismatch: expected %0d, got %0d",
                             $time, want.last, res_ch.last);
                end
            end
        end
    end

    task automatic send_item(input logic act, input logic [sdnt_pkg::LEN_W-1:0] len,
                             input logic [sdnt_pkg::HDR_W-1:0] hdr,
                             input logic [sdnt_pkg::HDR_W-1:0] red);
        int gap;
        @(negedge clk);
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 10);
            pkt_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        pkt_ch.valid          <= 1'b1;
        pkt_ch.action         <= act;
        pkt_ch.packet_length  <= len;
        pkt_ch.header_word    <= hdr;
        pkt_ch.redundant_word <= red;
        @(posedge clk);
        while (!pkt_ch.ready)
            @(posedge clk);
        predict_item(act, len, hdr, red);
    endtask

    task automatic send_packet(input logic [sdnt_pkg::LEN_W-1:0] len,
                               input logic [sdnt_pkg::HDR_W-1:0] hdr,
                               input logic [sdnt_pkg::HDR_W-1:0] red);
        send_item(1'b0, len, hdr, red);
    endtask

    task automatic send_tick();
        send_item(1'b1, sdnt_pkg::LEN_W'($urandom), sdnt_pkg::HDR_W'($urandom),
                  sdnt_pkg::HDR_W'($urandom));
    endtask

    // wait until all results are in and a scan that reports nothing has had time to finish
    task automatic settle_block();
        @(negedge clk);
        pkt_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (last_scan_reads + 64) @(posedge clk);
    endtask

    task automatic load_registers(input logic [sdnt_pkg::SEQ_W-1:0] back,
                                  input logic [sdnt_pkg::SEQ_W-1:0] guard,
                                  input logic [sdnt_pkg::LIMIT_W-1:0] lim,
                                  input logic [sdnt_pkg::TICK_W-1:0] every);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= sdnt_pkg::CFG_LOOK_BACK;
        cfg_data  <= sdnt_pkg::CFG_W'(back);
        @(negedge clk);
        cfg_index <= sdnt_pkg::CFG_GUARD_GAP;
        cfg_data  <= sdnt_pkg::CFG_W'(guard);
        @(negedge clk);
        cfg_index <= sdnt_pkg::CFG_REPORT_LIMIT;
        cfg_data  <= sdnt_pkg::CFG_W'(lim);
        @(negedge clk);
        cfg_index <= sdnt_pkg::CFG_SCAN_INTERVAL;
        cfg_data  <= every;
        @(negedge clk);
        cfg_we <= 1'b0;
        win_back   = back;
        win_guard  = guard;
        nack_limit = lim;
        scan_every = every;
    endtask

    task automatic test_length_and_duplicates();
        send_packet(12'd0, 16'hFFFF, 16'hFFFF);          // short, ignored
        send_packet(12'd161, 16'd5, 16'd0);
        send_tick();                                     // count already saturated
        send_packet(12'd162, 16'h0000, 16'h0000);        // highest below guard: no scan
        send_packet(12'd323, 16'h8003, 16'h0001);        // too short for the redundant copy
        send_packet(12'd324, 16'h8006, 16'h8001);        // redundant flag bit masked off
        send_packet(12'd2048, 16'h0006, 16'h0000);       // duplicate
        send_packet(12'd4095, 16'h8009, 16'h0009);       // same sequence twice
        send_packet(12'd500, 16'h8004, 16'h0003);        // redundant already seen
        settle_block();
        load_registers(15'd100, 15'd4, 6'd62, 16'd2);
        send_tick();
        send_tick();
        send_packet(12'd200, 16'd12, 16'd0);             // scan reports the holes up to 8
        send_packet(12'd200, 16'd10, 16'd0);             // late arrival, no scan yet
        settle_block();
    endtask

    task automatic test_register_extremes();
        load_registers(15'd0, 15'd0, 6'd1, 16'd0);
        send_packet(12'd400, 16'd40, 16'd0);
        send_packet(12'd400, 16'h802D, 16'd38);
        settle_block();
        load_registers(15'd32767, 15'd32767, 6'd63, 16'd65535);
        send_packet(12'd400, 16'd46, 16'd0);
        settle_block();
        // look-back below the guard: window is empty
        load_registers(15'd2, 15'd5, 6'd0, 16'd0);
        send_packet(12'd400, 16'd50, 16'd0);
        settle_block();
        load_registers(15'd10, 15'd1, 6'd0, 16'd0);
        send_packet(12'd400, 16'd53, 16'd0);
        settle_block();
        load_registers(15'd32767, 15'd1, 6'd63, 16'd1);
        send_tick();
        send_packet(12'd400, 16'd55, 16'd0);             // limit above the cap
        settle_block();
    endtask

    task automatic test_random_traffic(input int n_items);
        int counted;
        int roll;
        logic [sdnt_pkg::LEN_W-1:0] len;
        logic [sdnt_pkg::SEQ_W-1:0] s;
        logic [sdnt_pkg::SEQ_W-1:0] rs;
        counted = 0;
        while (counted < n_items)
        begin
            if (counted % 25 == 0)
                quiet = ($urandom_range(0, 2) == 0);
            roll = $urandom_range(0, 99);
            if (roll < 15)
                send_tick();
            else if (roll < 25)
                send_packet(sdnt_pkg::LEN_W'($urandom_range(0, 161)),
                            sdnt_pkg::HDR_W'($urandom), sdnt_pkg::HDR_W'($urandom));
            else
            begin
                roll = $urandom_range(0, 9);
                if (roll < 6)
                begin
                    stream_head = stream_head + sdnt_pkg::SEQ_W'($urandom_range(1, 4));
                    s = stream_head;
                end
                else if (roll < 9)
                    s = stream_head - sdnt_pkg::SEQ_W'($urandom_range(0, 12));
                else
                begin
                    // jump ahead, leaving a run of holes
                    stream_head = stream_head + sdnt_pkg::SEQ_W'($urandom_range(10, 60));
                    s = stream_head;
                end
                len = ($urandom_range(0, 3) == 0) ? sdnt_pkg::LEN_W'($urandom_range(162, 323))
                                                  : sdnt_pkg::LEN_W'($urandom_range(324, 4095));
                rs = stream_head - sdnt_pkg::SEQ_W'($urandom_range(0, 20));
                send_packet(len, {1'($urandom), s}, {1'($urandom), rs});
            end
            counted++;
        end
        quiet = 1'b0;
        settle_block();
    endtask

    task automatic test_output_backpressure();
        int i;
        load_registers(15'd30, 15'd2, 6'd62, 16'd0);
        hold_cycles = 300;
        for (i = 0; i < 12; i++)
        begin
            stream_head = stream_head + 15'd3;
            send_packet(12'd600, {1'b1, stream_head}, {1'b0, stream_head - 15'd1});
        end
        settle_block();
    endtask

    task automatic test_top_of_range();
        int i;
        logic [sdnt_pkg::SEQ_W-1:0] s;
        quiet = 1'b1;
        load_registers(15'd100, 15'd32767, 6'd62, 16'd0);
        send_packet(12'd324, 16'hFFFF, 16'hFFFF);       // start above end: nothing missing
        settle_block();
        load_registers(15'd100, 15'd0, 6'd62, 16'd0);
        send_packet(12'd2048, 16'h7FFE, 16'h0000);
        settle_block();
        load_registers(15'd32767, 15'd4, 6'd63, 16'd0);
        send_packet(12'd1000, 16'h7FF0, 16'h0000);
        for (i = 0; i < 10; i++)
        begin
            if ($urandom_range(0, 3) == 0)
                send_tick();
            else
            begin
                s = 15'h7FFF - sdnt_pkg::SEQ_W'($urandom_range(0, 60));
                send_packet(sdnt_pkg::LEN_W'($urandom_range(162, 4095)), {1'($urandom), s},
                            sdnt_pkg::HDR_W'($urandom));
            end
        end
        settle_block();
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        pkt_ch.valid = 1'b0;
        pkt_ch.action = 1'b0;
        pkt_ch.packet_length = '0;
        pkt_ch.header_word = '0;
        pkt_ch.redundant_word = '0;
        res_ch.ready = 1'b0;
        errors = 0;
        quiet = 1'b0;
        hold_cycles = 0;
        stall_left = 0;
        top_seq = '0;
        top_valid = 1'b0;
        ticks_since_scan = sdnt_pkg::TICK_MAX;
        win_back = sdnt_pkg::RST_LOOK_BACK;
        win_guard = sdnt_pkg::RST_GUARD_GAP;
        nack_limit = sdnt_pkg::RST_LIMIT;
        scan_every = sdnt_pkg::RST_INTERVAL;
        last_scan_reads = 0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_length_and_duplicates();
        test_register_extremes();
        // stream starts just below bit 14 so that it crosses it
        stream_head = 15'd16370;
        load_registers(15'd40, 15'd2, 6'($urandom_range(1, 62)), 16'd3);
        test_random_traffic(43);
        load_registers(15'd80, 15'd6, 6'd8, 16'd0);
        test_random_traffic(43);
        test_output_backpressure();
        test_top_of_range();

        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
